// ===== hw/rtl/per_node_load_quota_admission_defines.svh =====
// assertion macros for the admission block
`ifndef PER_NODE_LOAD_QUOTA_ADMISSION_DEFINES_SVH
`define PER_NODE_LOAD_QUOTA_ADMISSION_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PNLQA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define PNLQA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/pnlqa_pkg.sv =====
// constants and result codes of the admission block
package pnlqa_pkg;

  localparam int SUM_W  = 40;
  localparam int CNT_W  = 9;
  localparam int TC_W   = 24;
  localparam int ID_W   = 8;
  localparam int MAX_W  = 31;
  localparam int REM_W  = 42;
  localparam int NL_W   = 5;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [NL_W-1:0]  MAX_RES = 5'd16;

  typedef enum logic [2:0] {
    KIND_GRANTED  = 3'd0,
    KIND_QUEUED   = 3'd1,
    KIND_LAUNCHED = 3'd2,
    KIND_RELEASED = 3'd3,
    KIND_IDLE_ERR = 3'd4,
    KIND_FULL     = 3'd5
  } kind_t;

  typedef enum logic {
    MODE_REQUEST = 1'b0,
    MODE_FINISH  = 1'b1
  } mode_t;

endpackage

// ===== hw/rtl/per_node_load_quota_admission.sv =====
// per-node table-count admission: node state and waiting lists in block memories
// a grant or error passes ST_RDN, ST_DEC and ST_OUT, input ready again once back in ST_IDLE
// a queued request moves list entries up from the tail, a completion examines entries and
// shifts the list behind each launched entry; one item in flight
// one result per launch (a release if none), the final one held back to carry tlast; output stalls
// hold the walk; reset clears control, node state reads as zero through valid bits, lists need no clearing
module per_node_load_quota_admission #(
  parameter int NODES      = 16,
  parameter int WAIT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // node[3:0], task_id[11:4], table_count[35:12]
  input  logic        s_axis_tuser,   // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // task_id_res[7:0], node_res[11:8], table_count_res[35:12]
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [30:0] cfg_data        // max_node_tables
);

  localparam int LW  = $clog2(WAIT_DEPTH + 1);
  localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int AW  = (NODES * WAIT_DEPTH > 1) ? $clog2(NODES * WAIT_DEPTH) : 1;
  localparam int NDW = pnlqa_pkg::SUM_W + pnlqa_pkg::CNT_W + LW;
  localparam int WDW = pnlqa_pkg::ID_W + pnlqa_pkg::TC_W;
  localparam logic [LW-1:0] DEPTH_L = LW'(WAIT_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RDN, ST_DEC, ST_INS_RD, ST_INS_WR, ST_LAST_RD, ST_LAST_WT,
    ST_W_RD, ST_W_EV, ST_SH_RD, ST_SH_WR, ST_POST, ST_OUT, ST_FIN
  } state_t;

  state_t state;

  logic [30:0] max_tables;
  logic [3:0]  node_q;
  logic        mode_q;
  logic [7:0]  id_q;
  logic [23:0] tc_q;
  logic [39:0] sum;
  logic [8:0]  cnt;
  logic [LW-1:0] len;
  logic signed [41:0] remain;
  logic [LW-1:0] i_q;
  logic [LW-1:0] j_q;
  logic [4:0]  nl;
  logic [23:0] last_tc;
  logic        pend_v;
  logic [7:0]  pend_id;
  logic [23:0] pend_tc;
  logic [2:0]  okind;

  // node state memory with valid bits, wait-list memory
  logic [NDW-1:0] nmem [NODES];
  logic [NODES-1:0] nvalid;
  logic [NDW-1:0] nrd;
  logic           nrd_v;
  logic           n_we;
  logic [NDW-1:0] n_wd;

  logic [WDW-1:0] wmem [NODES*WAIT_DEPTH];
  logic [WDW-1:0] wrd;
  logic           w_we;
  logic [LW-1:0]  w_rslot;
  logic [LW-1:0]  w_wslot;
  logic [WDW-1:0] w_wd;
  logic [AW-1:0]  w_raddr;
  logic [AW-1:0]  w_waddr;

  logic [39:0] nsum;
  logic [8:0]  ncnt;
  logic [LW-1:0] nlen;
  logic [23:0] wrd_tc;
  logic [7:0]  wrd_id;
  logic [40:0] req_sum;
  logic [39:0] fin_sum;
  logic [40:0] sat_sum;
  logic        out_free;
  logic        fits;
  logic [LW-1:0] i_inc;
  logic [LW-1:0] len_dec;
  logic [LW-1:0] j_inc;
  logic        skip_ev;
  logic        out_load;

  assign nsum   = nrd_v ? nrd[NDW-1 -: 40] : '0;
  assign ncnt   = nrd_v ? nrd[LW +: 9] : '0;
  assign nlen   = nrd_v ? nrd[LW-1:0] : '0;
  assign wrd_tc = wrd[23:0];
  assign wrd_id = wrd[31:24];
  assign req_sum = {1'b0, nsum} + {17'b0, tc_q};
  assign fin_sum = (nsum >= {16'b0, tc_q}) ? nsum - {16'b0, tc_q} : '0;
  assign sat_sum = {1'b0, sum} + {17'b0, wrd_tc};
  assign fits    = (ncnt != pnlqa_pkg::CNT_MAX) && (req_sum <= {10'b0, max_tables});
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign i_inc   = i_q + LW'(1);
  assign len_dec = len - LW'(1);
  assign j_inc   = j_q + LW'(1);
  assign skip_ev = ($signed({18'b0, wrd_tc}) > remain) && (cnt != '0);

  // a beat is loaded into the output register this cycle
  assign out_load = out_free && ((state == ST_OUT) || (state == ST_FIN) ||
                    (state == ST_W_EV && !skip_ev && cnt != pnlqa_pkg::CNT_MAX && pend_v));

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;

  always_comb begin
    n_we    = 1'b0;
    n_wd    = {sum, cnt, len};
    w_we    = 1'b0;
    w_wslot = j_q;
    w_wd    = wrd;
    w_rslot = i_q;
    case (state)
      ST_DEC: begin
        if (mode_q == pnlqa_pkg::MODE_REQUEST) begin
          if (ncnt == '0) begin
            n_we = 1'b1;
            n_wd = {16'b0, tc_q, 9'd1, nlen};
          end else if (fits) begin
            n_we = 1'b1;
            n_wd = {req_sum[39:0], ncnt + 9'd1, nlen};
          end else if (nlen < DEPTH_L) begin
            n_we = 1'b1;
            n_wd = {nsum, ncnt, nlen + LW'(1)};
          end
        end
      end
      ST_INS_RD:  w_rslot = j_q - LW'(1);
      ST_INS_WR: begin
        w_we = 1'b1;
        if (j_q == '0 || wrd_tc >= tc_q) begin
          w_wd = {id_q, tc_q};
        end
      end
      ST_LAST_RD: w_rslot = len_dec;
      ST_SH_RD:   w_rslot = j_inc;
      ST_SH_WR:   w_we = 1'b1;
      ST_FIN:     n_we = out_free;
      default: begin
      end
    endcase
  end

  assign w_raddr = AW'(32'(node_q) * WAIT_DEPTH) + AW'(w_rslot);
  assign w_waddr = AW'(32'(node_q) * WAIT_DEPTH) + AW'(w_wslot);

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[NW'(node_q)] <= n_wd;
    end
    nrd   <= nmem[NW'(node_q)];
    nrd_v <= nvalid[NW'(node_q)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nvalid <= '0;
    end else if (n_we) begin
      nvalid[NW'(node_q)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[w_waddr] <= w_wd;
    end
    wrd <= wmem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tables <= '1;
    end else if (cfg_valid && cfg_ready) begin
      max_tables <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pend_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            node_q <= s_axis_tdata[3:0];
            id_q   <= s_axis_tdata[11:4];
            tc_q   <= s_axis_tdata[35:12];
            mode_q <= s_axis_tuser;
            // nodes beyond the configured count are dropped silently
            if (32'(s_axis_tdata[3:0]) < NODES) begin
              state <= ST_RDN;
            end
          end
        end
        ST_RDN: state <= ST_DEC;
        ST_DEC: begin
          if (mode_q == pnlqa_pkg::MODE_REQUEST) begin
            if (ncnt == '0 || fits) begin
              okind <= pnlqa_pkg::KIND_GRANTED;
              state <= ST_OUT;
            end else if (nlen < DEPTH_L) begin
              okind <= pnlqa_pkg::KIND_QUEUED;
              j_q   <= nlen;
              state <= (nlen == '0) ? ST_INS_WR : ST_INS_RD;
            end else begin
              okind <= pnlqa_pkg::KIND_FULL;
              state <= ST_OUT;
            end
          end else if (ncnt == '0) begin
            okind <= pnlqa_pkg::KIND_IDLE_ERR;
            state <= ST_OUT;
          end else begin
            sum    <= fin_sum;
            cnt    <= ncnt - 9'd1;
            len    <= nlen;
            remain <= $signed({11'b0, max_tables}) - $signed({2'b0, fin_sum});
            i_q    <= '0;
            nl     <= '0;
            state  <= (nlen == '0) ? ST_FIN : ST_LAST_RD;
          end
        end
        ST_INS_RD: state <= ST_INS_WR;
        ST_INS_WR: begin
          // walk from the tail, moving smaller entries up one place
          if (j_q == '0 || wrd_tc >= tc_q) begin
            state <= ST_OUT;
          end else begin
            j_q   <= j_q - LW'(1);
            state <= ST_INS_RD;
          end
        end
        ST_LAST_RD: state <= ST_LAST_WT;
        ST_LAST_WT: begin
          last_tc <= wrd_tc;
          state   <= ST_W_RD;
        end
        ST_W_RD: state <= ST_W_EV;
        ST_W_EV: begin
          if (skip_ev) begin
            i_q   <= i_inc;
            state <= (i_inc < len && nl < pnlqa_pkg::MAX_RES) ? ST_W_RD : ST_FIN;
          end else if (cnt == pnlqa_pkg::CNT_MAX) begin
            state <= ST_FIN;
          end else if (!pend_v || out_free) begin
            if (pend_v) begin
              m_axis_tdata  <= {4'b0, pend_tc, node_q, pend_id};
              m_axis_tuser  <= pnlqa_pkg::KIND_LAUNCHED;
              m_axis_tlast  <= 1'b0;
            end
            pend_v  <= 1'b1;
            pend_id <= wrd_id;
            pend_tc <= wrd_tc;
            nl      <= nl + 5'd1;
            sum     <= sat_sum[40] ? '1 : sat_sum[39:0];
            cnt     <= cnt + 9'd1;
            remain  <= remain - $signed({18'b0, wrd_tc});
            j_q     <= i_q;
            state   <= (i_inc < len) ? ST_SH_RD : ST_POST;
          end
        end
        ST_SH_RD: state <= ST_SH_WR;
        ST_SH_WR: begin
          j_q   <= j_inc;
          state <= (j_inc + LW'(1) < len) ? ST_SH_RD : ST_POST;
        end
        ST_POST: begin
          len <= len_dec;
          if (remain[41] || remain == '0) begin
            state <= ST_FIN;
          end else if (i_q < len_dec && remain < $signed({18'b0, last_tc})) begin
            state <= ST_FIN;
          end else if (i_q < len_dec && nl < pnlqa_pkg::MAX_RES) begin
            state <= ST_W_RD;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_axis_tdata  <= {4'b0, tc_q, node_q, id_q};
            m_axis_tuser  <= okind;
            m_axis_tlast  <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tlast  <= 1'b1;
            if (pend_v) begin
              m_axis_tdata <= {4'b0, pend_tc, node_q, pend_id};
              m_axis_tuser <= pnlqa_pkg::KIND_LAUNCHED;
            end else begin
              m_axis_tdata <= {4'b0, tc_q, node_q, id_q};
              m_axis_tuser <= pnlqa_pkg::KIND_RELEASED;
            end
            pend_v <= 1'b0;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`include "per_node_load_quota_admission_defines.svh"

  // a held launch never outlives its completion walk
  `PNLQA_ASSERT_IMP(a_pend_in_walk, pend_v, state != ST_IDLE && state != ST_OUT)
  // launches per completion stay within the result limit
  `PNLQA_ASSERT_IMP(a_launch_bound, state == ST_W_EV || state == ST_POST, nl <= pnlqa_pkg::MAX_RES)
  // an accepted item always leaves idle unless its node is out of range
  `PNLQA_ASSERT_NXT(a_accept_moves, s_axis_tvalid && s_axis_tready && 32'(s_axis_tdata[3:0]) < NODES, state == ST_RDN)

endmodule
